[hw/rtl/gmsb_pkg.sv]
// ----------------------------------------------------------------------------
// gmsb_pkg
// Shared types and constants of the grid breadth-first search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gmsb_pkg;

   localparam int GMSB_MAX_ROWS = 64;
   localparam int GMSB_MAX_COLS = 64;

   localparam int GRID_W    = 7;
   localparam int COORD_W   = 6;
   localparam int DIST_W    = 12;
   localparam int DIST_SAT  = 4095;
   localparam int CSR_IDX_W = 1;

   localparam logic [GRID_W-1:0]    GRID_RESET = 7'd64;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS   = 1'b1;

   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               wall;
      logic               src;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_READW,
      ST_SWEEP,
      ST_POP,
      ST_POPW,
      ST_NB,
      ST_NBW,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/grid_multi_source_bfs.sv]
// ----------------------------------------------------------------------------
// grid_multi_source_bfs
// Multi-source breadth-first search over a 4-connected grid of cells.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | start / busy         | req_opcode, req_row, req_col,
//           |                      | req_is_wall, req_is_source
//  response | rsp_valid (1 cycle)  | rsp_kind, rsp_distance, rsp_reached
//  csr      | csr_we               | csr_index, csr_wdata
//
//  An item is taken when start is high and busy is low; a two-entry queue
//  sits between the request side and the engine.
//  Load writes the cell map; read addresses the distance map, then registers
//  the response. Run: one sweep over every map address to clear distances
//  and seed sources, then per reached cell a FIFO pop plus four neighbour
//  probes through the single-read-port memories, then the done strobe.
//  After reset a clearing pass over every map address wipes the maps; busy
//  stays high for it. CSR writes are taken at any time.
//  The response side cannot stall; each response is a single-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_multi_source_bfs import gmsb_pkg::*; #(
   parameter int MAX_ROWS = GMSB_MAX_ROWS,
   parameter int MAX_COLS = GMSB_MAX_COLS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic                 req_is_wall,
   input  wire logic                 req_is_source,
   output logic                      rsp_valid,
   output logic                      rsp_kind,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_reached,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GRID_W-1:0]    csr_wdata
);

   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);

   // grid size registers, clamped to the built maximum
   logic [GRID_W-1:0] grid_rows_ff, grid_rows_in;
   logic [GRID_W-1:0] grid_cols_ff, grid_cols_in;
   logic [RCW-1:0]    eff_rows;
   logic [CCW-1:0]    eff_cols;

   logic            q_valid, q_pop;
   cmd_type         q_cmd;
   back_status_type status;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ROWS: grid_rows_in = csr_wdata;
            CSR_COLS: grid_cols_in = csr_wdata;
            default:  grid_rows_in = grid_rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= GRID_RESET;
         grid_cols_ff <= GRID_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   assign eff_rows = (32'(grid_rows_ff) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(grid_rows_ff);
   assign eff_cols = (32'(grid_cols_ff) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(grid_cols_ff);

   // front: accept and queue
   gmsb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_is_wall   (req_is_wall),
      .req_is_source (req_is_source),
      .status        (status),
      .busy          (busy),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop)
   );

   // back: memories and search engine
   gmsb_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .eff_rows     (eff_rows),
      .eff_cols     (eff_cols),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_distance (rsp_distance),
      .rsp_reached  (rsp_reached)
   );

endmodule

`default_nettype wire

[hw/rtl/gmsb_front.sv]
// ----------------------------------------------------------------------------
// gmsb_front
// Takes items, drops unknown opcodes and queues the rest for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsb_front import gmsb_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [COORD_W-1:0] req_row,
   input  wire logic [COORD_W-1:0] req_col,
   input  wire logic               req_is_wall,
   input  wire logic               req_is_source,
   input  wire back_status_type    status,
   output logic                    busy,
   output logic                    q_valid,
   output cmd_type                 q_cmd,
   input  wire logic               q_pop
);

   cmd_type    q_mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    new_cmd;

   always_comb begin
      new_cmd.op   = op_type'(req_opcode);
      new_cmd.row  = req_row;
      new_cmd.col  = req_col;
      new_cmd.wall = req_is_wall;
      new_cmd.src  = req_is_source;
   end

   assign busy    = status.clearing || (cnt_ff == 2'd2);
   assign push    = start && !busy && (req_opcode inside {OP_LOAD, OP_RUN, OP_READ});
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd   = q_mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = ~wp_ff;
      end
      if (q_pop) begin
         rp_in = ~rp_ff;
      end
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wp_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/gmsb_back.sv]
// ----------------------------------------------------------------------------
// gmsb_back
// Engine: cell and distance memories, frontier FIFO and the search sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsb_back import gmsb_pkg::*; #(
   parameter int MAX_ROWS = GMSB_MAX_ROWS,
   parameter int MAX_COLS = GMSB_MAX_COLS,
   localparam int RCW = $clog2(MAX_ROWS + 1),
   localparam int CCW = $clog2(MAX_COLS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [RCW-1:0]    eff_rows,
   input  wire logic [CCW-1:0]    eff_cols,
   input  wire logic              q_valid,
   input  wire cmd_type           q_cmd,
   output logic                   q_pop,
   output back_status_type        status,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [DIST_W-1:0]      rsp_distance,
   output logic                   rsp_reached
);

   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLS);
   localparam int AW    = RB + CB;
   localparam int DEPTH = 2 ** AW;
   localparam int DW    = $clog2(MAX_ROWS * MAX_COLS);

   // cell map entry: {wall, source}; distance entry: {reached, distance}
   logic [1:0]     cellmap_ff [DEPTH];
   logic [DW:0]    distmap_ff [DEPTH];
   logic [AW+DW-1:0] fifo_ff   [DEPTH];

   logic [1:0]       cm_q_ff;
   logic [DW:0]      dm_q_ff;
   logic [AW+DW-1:0] fifo_q_ff;

   logic             cm_we, dm_we, fifo_we;
   logic [AW-1:0]    cm_wa, dm_wa, cm_ra, dm_ra, fifo_wa, fifo_ra;
   logic [1:0]       cm_wd;
   logic [DW:0]      dm_wd;
   logic [AW+DW-1:0] fifo_wd;

   back_state_type state_ff, state_in;
   logic [AW:0]    sw_ff, sw_in;
   logic [AW:0]    head_ff, head_in, tail_ff, tail_in;
   logic           sv_ff, sv_in;
   logic [AW-1:0]  sa_ff, sa_in;
   logic [AW-1:0]  cur_addr_ff, cur_addr_in;
   logic [DW-1:0]  cur_dist_ff, cur_dist_in;
   logic [1:0]     k_ff, k_in;
   logic           hit_ff, hit_in;
   cmd_type        cmd_ff, cmd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_kind_ff, rsp_kind_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic           rsp_reached_ff, rsp_reached_in;

   logic [RB-1:0]  cr;
   logic [CB-1:0]  cc;
   logic [AW-1:0]  n_addr, cmd_addr;
   logic           n_inb;
   logic [DW-1:0]  nd;

   function automatic logic active(input logic [RB-1:0] r, input logic [CB-1:0] c,
                                   input logic [RCW-1:0] er, input logic [CCW-1:0] ec);
      return (32'(r) < 32'(er)) && (32'(c) < 32'(ec));
   endfunction

   function automatic logic [DIST_W-1:0] sat_dist(input logic [DW-1:0] d);
      return (32'(d) > DIST_SAT) ? DIST_W'(DIST_SAT) : DIST_W'(d);
   endfunction

   assign cr       = cur_addr_ff[AW-1:CB];
   assign cc       = cur_addr_ff[CB-1:0];
   assign nd       = cur_dist_ff + DW'(1);
   assign cmd_addr = {RB'(cmd_ff.row), CB'(cmd_ff.col)};

   // neighbour order: right, left, down, up
   always_comb begin
      case (k_ff)
         2'd0: begin
            n_addr = {cr, CB'(cc + 1'b1)};
            n_inb  = (32'(cc) + 1) < 32'(eff_cols);
         end
         2'd1: begin
            n_addr = {cr, CB'(cc - 1'b1)};
            n_inb  = (cc != '0);
         end
         2'd2: begin
            n_addr = {RB'(cr + 1'b1), cc};
            n_inb  = (32'(cr) + 1) < 32'(eff_rows);
         end
         default: begin
            n_addr = {RB'(cr - 1'b1), cc};
            n_inb  = (cr != '0);
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      sw_in          = sw_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      sv_in          = 1'b0;
      sa_in          = sa_ff;
      cur_addr_in    = cur_addr_ff;
      cur_dist_in    = cur_dist_ff;
      k_in           = k_ff;
      hit_in         = hit_ff;
      cmd_in         = cmd_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_reached_in = rsp_reached_ff;
      q_pop          = 1'b0;
      cm_we          = 1'b0;
      cm_wa          = sw_ff[AW-1:0];
      cm_wd          = 2'b00;
      cm_ra          = sw_ff[AW-1:0];
      dm_we          = 1'b0;
      dm_wa          = sw_ff[AW-1:0];
      dm_wd          = '0;
      dm_ra          = n_addr;
      fifo_we        = 1'b0;
      fifo_wa        = tail_ff[AW-1:0];
      fifo_wd        = '0;
      fifo_ra        = head_ff[AW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            cm_we = 1'b1;
            dm_we = 1'b1;
            sw_in = sw_ff + 1'b1;
            if (sw_ff[AW-1:0] == '1) begin
               sw_in    = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               case (q_cmd.op)
                  OP_LOAD: state_in = ST_LOAD;
                  OP_RUN: begin
                     sw_in    = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            if ((32'(cmd_ff.row) < MAX_ROWS) && (32'(cmd_ff.col) < MAX_COLS)) begin
               cm_we = 1'b1;
               cm_wa = cmd_addr;
               cm_wd = {cmd_ff.wall, cmd_ff.src};
            end
            state_in = ST_IDLE;
         end
         ST_READ: begin
            dm_ra    = cmd_addr;
            hit_in   = (32'(cmd_ff.row) < 32'(eff_rows)) &&
                       (32'(cmd_ff.col) < 32'(eff_cols));
            state_in = ST_READW;
         end
         ST_READW: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_READ;
            rsp_reached_in = hit_ff && dm_q_ff[DW];
            rsp_dist_in    = (hit_ff && dm_q_ff[DW]) ? sat_dist(dm_q_ff[DW-1:0]) : '0;
            state_in       = ST_IDLE;
         end
         ST_SWEEP: begin
            // clear every distance entry and seed sources in row-major order
            if (!sw_ff[AW]) begin
               cm_ra = sw_ff[AW-1:0];
               sv_in = 1'b1;
               sa_in = sw_ff[AW-1:0];
               sw_in = sw_ff + 1'b1;
            end
            if (sv_ff) begin
               dm_we = 1'b1;
               dm_wa = sa_ff;
               if (active(sa_ff[AW-1:CB], sa_ff[CB-1:0], eff_rows, eff_cols) &&
                   cm_q_ff[0] && !cm_q_ff[1]) begin
                  dm_wd   = {1'b1, DW'(0)};
                  fifo_we = 1'b1;
                  fifo_wd = {sa_ff, DW'(0)};
                  tail_in = tail_ff + 1'b1;
               end
            end
            if (sw_ff[AW] && !sv_ff) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               head_in  = head_ff + 1'b1;
               state_in = ST_POPW;
            end
         end
         ST_POPW: begin
            cur_addr_in = fifo_q_ff[AW+DW-1:DW];
            cur_dist_in = fifo_q_ff[DW-1:0];
            k_in        = 2'd0;
            state_in    = ST_NB;
         end
         ST_NB, ST_NBW: begin
            if (state_ff == ST_NB) begin
               cm_ra = n_addr;
               sv_in = n_inb;
               sa_in = n_addr;
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd3) begin
                  state_in = ST_NBW;
               end
            end else begin
               state_in = ST_POP;
            end
            if (sv_ff && !cm_q_ff[1] && !dm_q_ff[DW]) begin
               dm_we   = 1'b1;
               dm_wa   = sa_ff;
               dm_wd   = {1'b1, nd};
               fifo_we = 1'b1;
               fifo_wd = {sa_ff, nd};
               tail_in = tail_ff + 1'b1;
            end
         end
         ST_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_DONE;
            rsp_reached_in = 1'b0;
            rsp_dist_in    = '0;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sw_ff        <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         sv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         sv_ff        <= sv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff          <= sa_in;
      cur_addr_ff    <= cur_addr_in;
      cur_dist_ff    <= cur_dist_in;
      k_ff           <= k_in;
      hit_ff         <= hit_in;
      cmd_ff         <= cmd_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_dist_ff    <= rsp_dist_in;
      rsp_reached_ff <= rsp_reached_in;
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         cellmap_ff[cm_wa] <= cm_wd;
      end
      cm_q_ff <= cellmap_ff[cm_ra];
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         distmap_ff[dm_wa] <= dm_wd;
      end
      dm_q_ff <= distmap_ff[dm_ra];
   end

   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_ff[fifo_wa] <= fifo_wd;
      end
      fifo_q_ff <= fifo_ff[fifo_ra];
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_reached     = rsp_reached_ff;

endmodule

`default_nettype wire

[hw/rtl/gmsb_checker.sv]
// ----------------------------------------------------------------------------
// gmsb_port_checks
// Port-level checks on the search block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsb_port_checks import gmsb_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic              rsp_kind,
   input wire logic [DIST_W-1:0] rsp_distance,
   input wire logic              rsp_reached
);

   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("no clearing pass after reset");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses back to back");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_DONE) |-> !rsp_reached && (rsp_distance == '0))
      else $error("done response carries data");

   a_unreached_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_reached |-> (rsp_distance == '0))
      else $error("distance on unreached cell");

endmodule

bind grid_multi_source_bfs gmsb_port_checks u_gmsb_port_checks (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_kind     (rsp_kind),
   .rsp_distance (rsp_distance),
   .rsp_reached  (rsp_reached)
);

`default_nettype wire

[tb/sv/gmsb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmsb_checker
// Watches the request, CSR and response ports of the grid search block,
// predicts each response with its own grid maps and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module gmsb_checker import gmsb_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   input  wire logic                 req_is_wall,
   input  wire logic                 req_is_source,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_kind,
   input  wire logic [DIST_W-1:0]    rsp_distance,
   input  wire logic                 rsp_reached,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GRID_W-1:0]    csr_wdata,
   output int                        errors,
   output int                        pending
);

   localparam int CELLS = GMSB_MAX_ROWS * GMSB_MAX_COLS;

   typedef struct packed {
      logic              kind;
      logic [DIST_W-1:0] distance;
      logic              reached;
   } grid_rsp_type;

   logic        wall_bit  [CELLS];
   logic        src_bit   [CELLS];
   logic        seen_bit  [CELLS];
   int          hop_count [CELLS];
   logic [GRID_W-1:0] rows_reg;
   logic [GRID_W-1:0] cols_reg;
   grid_rsp_type rsp_due_q[$];

   function automatic int active_rows();
      return (rows_reg > GMSB_MAX_ROWS) ? GMSB_MAX_ROWS : int'(rows_reg);
   endfunction

   function automatic int active_cols();
      return (cols_reg > GMSB_MAX_COLS) ? GMSB_MAX_COLS : int'(cols_reg);
   endfunction

   // mark on enqueue
   function automatic void mark_cell(int r, int c, int d, ref int frontier[$]);
      int idx;
      idx = r * GMSB_MAX_COLS + c;
      if (wall_bit[idx] || seen_bit[idx]) return;
      seen_bit[idx]  = 1'b1;
      hop_count[idx] = d;
      frontier.push_back(idx);
   endfunction

   function automatic void flood_distances();
      int frontier[$];
      int nr, nc, idx, cr, cc, nd;
      nr = active_rows();
      nc = active_cols();
      for (int i = 0; i < CELLS; i++) begin
         seen_bit[i]  = 1'b0;
         hop_count[i] = 0;
      end
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (src_bit[r * GMSB_MAX_COLS + c]) mark_cell(r, c, 0, frontier);
      while (frontier.size() > 0) begin
         idx = frontier.pop_front();
         cr  = idx / GMSB_MAX_COLS;
         cc  = idx % GMSB_MAX_COLS;
         nd  = hop_count[idx] + 1;
         // right, left, down, up
         if (cc + 1 < nc) mark_cell(cr, cc + 1, nd, frontier);
         if (cc > 0)      mark_cell(cr, cc - 1, nd, frontier);
         if (cr + 1 < nr) mark_cell(cr + 1, cc, nd, frontier);
         if (cr > 0)      mark_cell(cr - 1, cc, nd, frontier);
      end
   endfunction

   always @(posedge clock) begin
      grid_rsp_type due, got;
      int idx;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            wall_bit[i]  = 1'b0;
            src_bit[i]   = 1'b0;
            seen_bit[i]  = 1'b0;
            hop_count[i] = 0;
         end
         rows_reg = GRID_RESET;
         cols_reg = GRID_RESET;
         rsp_due_q.delete();
         errors <= 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_kind, rsp_distance, rsp_reached};
            if (rsp_due_q.size() == 0) begin
               $display("%0t: unexpected response kind=%0b dist=%0d reached=%0b",
                        $time, got.kind, got.distance, got.reached);
               errors <= errors + 1;
            end else begin
               due = rsp_due_q.pop_front();
               if (got !== due) begin
                  $display("%0t: response mismatch exp kind=%0b dist=%0d reached=%0b",
                           $time, due.kind, due.distance, due.reached);
                  $display("%0t:                   got kind=%0b dist=%0d reached=%0b",
                           $time, got.kind, got.distance, got.reached);
                  errors <= errors + 1;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_ROWS) rows_reg = csr_wdata;
            else                       cols_reg = csr_wdata;
         end
         if (start && !busy) begin
            idx = int'(req_row) * GMSB_MAX_COLS + int'(req_col);
            case (req_opcode)
               OP_LOAD: begin
                  wall_bit[idx] = req_is_wall;
                  src_bit[idx]  = req_is_source;
               end
               OP_RUN: begin
                  flood_distances();
                  rsp_due_q.push_back('{KIND_DONE, '0, 1'b0});
               end
               OP_READ: begin
                  due = '{KIND_READ, '0, 1'b0};
                  if (req_row < active_rows() && req_col < active_cols() && seen_bit[idx])
                  begin
                     due.reached  = 1'b1;
                     due.distance = (hop_count[idx] > DIST_SAT) ? DIST_SAT[DIST_W-1:0]
                                                                : hop_count[idx][DIST_W-1:0];
                  end
                  rsp_due_q.push_back(due);
               end
               default: ;  // unused opcode, no response
            endcase
         end
      end
      pending <= rsp_due_q.size();
   end

endmodule

`default_nettype wire

[tb/sv/tb_grid_multi_source_bfs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_multi_source_bfs
// Drives load, run and read items into the grid search block across several
// grid sizes with random gaps; the checker predicts and compares responses.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_multi_source_bfs;
   import gmsb_pkg::*;

   // opcode outside the defined set, dropped without a response
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [1:0]           req_opcode = OP_LOAD;
   logic [COORD_W-1:0]   req_row = '0;
   logic [COORD_W-1:0]   req_col = '0;
   logic                 req_is_wall = 1'b0;
   logic                 req_is_source = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_kind;
   logic [DIST_W-1:0]    rsp_distance;
   logic                 rsp_reached;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROWS;
   logic [GRID_W-1:0]    csr_wdata = '0;
   int                   errors;
   int                   pending;

   // grid size the stimulus aims its coordinates at
   int  act_rows = 64;
   int  act_cols = 64;
   // when set, items go back to back
   bit  no_gaps = 1'b0;

   always #10 clock = ~clock;

   grid_multi_source_bfs dut (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_row, .req_col, .req_is_wall, .req_is_source,
      .rsp_valid, .rsp_kind, .rsp_distance, .rsp_reached,
      .csr_we, .csr_index, .csr_wdata
   );

   gmsb_checker chk (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_row, .req_col, .req_is_wall, .req_is_source,
      .rsp_valid, .rsp_kind, .rsp_distance, .rsp_reached,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .pending
   );

   // One item: optional gap, then hold start until an edge sees busy low.
   // busy only moves on the rising edge, so the value at the falling edge
   // is the one the next rising edge samples.
   task automatic send_item(logic [1:0] op, int r, int c, bit w, bit s);
      int  gap;
      bit  was_busy;
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start         = 1'b1;
      req_opcode    = op;
      req_row       = r[COORD_W-1:0];
      req_col       = c[COORD_W-1:0];
      req_is_wall   = w;
      req_is_source = s;
      do begin
         was_busy = busy;
         @(negedge clock);
      end while (was_busy);
   endtask

   // Grid size changes only with the engine quiet: all responses in, then
   // a margin for a trailing load that has no response.
   task automatic set_grid(int rows, int cols);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_ROWS;
      csr_wdata = rows[GRID_W-1:0];
      @(negedge clock);
      csr_index = CSR_COLS;
      csr_wdata = cols[GRID_W-1:0];
      @(negedge clock);
      csr_we   = 1'b0;
      act_rows = (rows > 64) ? 64 : rows;
      act_cols = (cols > 64) ? 64 : cols;
   endtask

   // coordinate mostly inside the active grid, now and then anywhere
   function automatic int pick_coord(int span);
      if (span == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, span - 1);
   endfunction

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 10)
         send_item(OP_LOAD, pick_coord(act_rows), pick_coord(act_cols),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
      else if (pick < 12)
         send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else if (pick < 19)
         send_item(OP_READ, pick_coord(act_rows), pick_coord(act_cols),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
         send_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), 1'b1, 1'b1);
   endtask

   initial begin
      int rows, cols, loads;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: full 64x64 grid from reset, corner cells, walls, sources
      send_item(OP_LOAD, 0, 0, 1'b0, 1'b1);
      send_item(OP_LOAD, 63, 63, 1'b1, 1'b1);    // walled source is not seeded
      send_item(OP_LOAD, 0, 1, 1'b1, 1'b0);
      send_item(OP_LOAD, 1, 0, 1'b1, 1'b0);      // (0,0) boxed in
      send_item(OP_LOAD, 32, 17, 1'b0, 1'b1);
      send_item(OP_UNUSED, 63, 63, 1'b1, 1'b1);  // unused opcode, ignored
      send_item(OP_RUN, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 63, 63, 1'b0, 1'b0);
      send_item(OP_READ, 0, 1, 1'b0, 1'b0);
      send_item(OP_READ, 63, 0, 1'b0, 1'b0);
      send_item(OP_READ, 1, 1, 1'b0, 1'b0);      // reached around the walls from (32,17)
      // empty grid still gives a done response
      set_grid(0, 127);
      send_item(OP_RUN, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 32, 17, 1'b0, 1'b0);
      // oversize rows saturate, single column
      set_grid(127, 1);
      send_item(OP_RUN, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 63, 0, 1'b0, 1'b0);
      send_item(OP_READ, 32, 1, 1'b0, 1'b0);     // outside active columns
      set_grid(1, 1);
      send_item(OP_RUN, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 0, 0, 1'b0, 1'b0);
      send_item(OP_READ, 0, 63, 1'b0, 1'b0);

      // random phases: mostly small grids, loads, a run, reads, then random items
      for (int ph = 0; ph < 7; ph++) begin
         case ($urandom_range(0, 7))
            0:       begin rows = 64; cols = $urandom_range(1, 64); end
            1:       begin rows = $urandom_range(0, 127); cols = $urandom_range(0, 9); end
            default: begin rows = $urandom_range(1, 10); cols = $urandom_range(1, 10); end
         endcase
         set_grid(rows, cols);
         no_gaps = (ph % 3 == 1);
         loads = $urandom_range(2, 5);
         repeat (loads)
            send_item(OP_LOAD, pick_coord(act_rows), pick_coord(act_cols),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
         send_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), 1'b0, 1'b0);
         repeat (4)
            send_item(OP_READ, pick_coord(act_rows), pick_coord(act_cols), 1'b0, 1'b0);
         repeat (3) random_item();
      end

      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
